>>> rtl/point_in_polygon_crossing_test_defines.svh
// Assertion macros for the point-in-polygon block.
// Used by point_in_polygon_crossing_test.sv; expects clk and rst in scope.
`ifndef POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_CROSSING_TEST_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define PIP_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("pip assertion failed");

// Next-cycle implication, checked outside reset.
`define PIP_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("pip assertion failed");

`endif

>>> rtl/pip_pkg.sv
// Shared types and codes for the point-in-polygon block.
// No dependencies.
package pip_pkg;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_WAIT,
    ST_FINISH
  } st_t;

  localparam logic [1:0] OP_CLEAR  = 2'd0;
  localparam logic [1:0] OP_APPEND = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam int CNT_W  = 9;
  localparam int OUT_W  = 16;
  localparam int TOL_W  = 16;
  localparam logic [CNT_W-1:0] CNT_MAX = '1;

endpackage

>>> rtl/point_in_polygon_crossing_test.sv
// Point-in-polygon test by crossing number with a boundary tolerance.
// Depends on pip_pkg.sv and point_in_polygon_crossing_test_defines.svh.
//
//  channel   | dir | handshake              | payload
//  ----------+-----+------------------------+----------------------------------
//  s_axis    | in  | s_axis_tvalid/tready   | tdata: opcode, coord_x, coord_y
//  m_axis    | out | m_axis_tvalid/tready   | tdata: inside_res, on_boundary,
//            |     |                        |        crossing_count, status
//  cfg       | in  | cfg_wr_en              | cfg_wr_data: boundary_tolerance_sq
//
// Clear and append are accepted, then their result is loaded. A query of
// n stored vertices runs from its transfer to the next ready through
// n vertex reads, one per cycle through the single read port of the vertex
// memory, then read latency, the closing edge, the edge register, five
// evaluation stages and the accumulate, the result latch and the load.
// rst is synchronous and clears control state only; the vertex memory is
// never cleared. A stalled result waits in the output register while the
// next item is accepted and worked on; a second result holds in FINISH.
`include "point_in_polygon_crossing_test_defines.svh"

module point_in_polygon_crossing_test #(
  parameter int MAX_VERTICES = 256,
  parameter int COORD_BITS   = 16
) (
  input  logic clk,
  input  logic rst,
  input  logic s_axis_tvalid,
  output logic s_axis_tready,
  // opcode [1:0], coord_x, coord_y, zero padding
  input  logic [((2 + 2*COORD_BITS) + 7) / 8 * 8 - 1:0] s_axis_tdata,
  output logic m_axis_tvalid,
  input  logic m_axis_tready,
  // inside_res [0], on_boundary [1], crossing_count [10:2], status [12:11], zeros
  output logic [pip_pkg::OUT_W-1:0] m_axis_tdata,
  input  logic cfg_wr_en,
  input  logic [pip_pkg::TOL_W-1:0] cfg_wr_data
);

  localparam int C   = COORD_BITS;
  localparam int D   = C + 1;              // coordinate difference
  localparam int P   = 2 * D;              // product
  localparam int S   = P + 1;              // sum of two products
  localparam int Q   = 2 * S;              // squared cross product
  localparam int AW  = $clog2(MAX_VERTICES);
  localparam int CW  = $clog2(MAX_VERTICES + 1);
  localparam logic [CW-1:0] MAXV = CW'(MAX_VERTICES);
  localparam logic [pip_pkg::CNT_W-1:0] CNT_ONE = 1;

  // ---------------------------------------------------------------- state
  pip_pkg::st_t state, state_next;

  logic [CW-1:0] count;
  logic [CW-1:0] n;
  logic [CW-1:0] issue;
  logic [pip_pkg::TOL_W-1:0] tol;
  logic signed [C-1:0] px, py;

  logic                    r_inside, r_onb;
  logic [pip_pkg::CNT_W-1:0] r_cnt;
  logic [1:0]              r_status;

  logic                    acc_onb;
  logic [pip_pkg::CNT_W-1:0] acc_cnt;

  // Vertex memory, one synchronous read port.
  logic signed [C-1:0] x_mem [MAX_VERTICES];
  logic signed [C-1:0] y_mem [MAX_VERTICES];
  logic signed [C-1:0] rx, ry;
  logic rd_v, rd_first, rd_last, close_pend;
  logic signed [C-1:0] fx, fy, prvx, prvy;

  // Input field split.
  logic [1:0]          in_op;
  logic signed [C-1:0] in_x, in_y;
  assign in_op = s_axis_tdata[1:0];
  assign in_x  = s_axis_tdata[C+1:2];
  assign in_y  = s_axis_tdata[2*C+1:C+2];

  logic in_acc, out_free, pipe_empty, app_ok;
  assign s_axis_tready = (state == pip_pkg::ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign app_ok        = in_acc && in_op == pip_pkg::OP_APPEND && count < MAXV;

  // ---------------------------------------------------------------- edge pipe
  logic e_v, s1_v, s2_v, s3_v, s4_v, s5_v;
  logic signed [C-1:0] ax, ay, bx, by;

  logic signed [D-1:0] s1_dx, s1_dy, s1_wx, s1_wy, s1_vx, s1_vy;
  logic s1_yin, s1_dypos;

  logic signed [P-1:0] s2_dxwx, s2_dywy, s2_dxdx, s2_dydy, s2_dxwy, s2_dywx;
  logic signed [P-1:0] s2_wxwx, s2_wywy, s2_vxvx, s2_vyvy, s2_lhs, s2_rhs;
  logic s2_yin, s2_dypos;

  logic signed [S-1:0] s3_t, s3_l, s3_cr, s3_da, s3_db;
  logic s3_xc;

  logic [S-1:0] s4_acr, s4_l;
  logic s4_ptmode, s4_ptnear, s4_xc;

  logic [Q-1:0] s5_sq, s5_tl;
  logic s5_big, s5_ptmode, s5_ptnear, s5_xc;

  logic [127:0] acr_wide;
  logic signed [S-1:0] cr_abs;
  logic near6, t_nonpos;

  assign cr_abs   = s3_cr[S-1] ? -s3_cr : s3_cr;
  assign acr_wide = 128'(s4_acr);
  assign near6    = s5_ptmode ? s5_ptnear : (!s5_big && (s5_tl >= s5_sq));
  assign t_nonpos = s3_t[S-1] || (s3_t == '0);

  assign pipe_empty = !rd_v && !close_pend && !e_v && !s1_v && !s2_v
                      && !s3_v && !s4_v && !s5_v;

  // ---------------------------------------------------------------- next state
  always_comb begin
    state_next = state;
    case (state)
      pip_pkg::ST_IDLE: begin
        if (in_acc) begin
          if (in_op == pip_pkg::OP_QUERY && count != '0) state_next = pip_pkg::ST_RUN;
          else state_next = pip_pkg::ST_FINISH;
        end
      end
      pip_pkg::ST_RUN: begin
        if (issue == n - CW'(1)) state_next = pip_pkg::ST_WAIT;
      end
      pip_pkg::ST_WAIT: begin
        if (pipe_empty) state_next = pip_pkg::ST_FINISH;
      end
      pip_pkg::ST_FINISH: begin
        if (out_free) state_next = pip_pkg::ST_IDLE;
      end
      default: state_next = pip_pkg::ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------- memory
  always_ff @(posedge clk) begin
    if (app_ok) begin
      x_mem[count[AW-1:0]] <= in_x;
      y_mem[count[AW-1:0]] <= in_y;
    end
    if (state == pip_pkg::ST_RUN) begin
      rx <= x_mem[issue[AW-1:0]];
      ry <= y_mem[issue[AW-1:0]];
    end
  end

  // ---------------------------------------------------------------- control
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= pip_pkg::ST_IDLE;
      count         <= '0;
      tol           <= '0;
      m_axis_tvalid <= 1'b0;
      rd_v          <= 1'b0;
      close_pend    <= 1'b0;
      e_v  <= 1'b0;
      s1_v <= 1'b0;
      s2_v <= 1'b0;
      s3_v <= 1'b0;
      s4_v <= 1'b0;
      s5_v <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) tol <= cfg_wr_data;

      // Load a new result in FINISH; drop the old one once the sink takes it.
      if (state == pip_pkg::ST_FINISH && out_free) m_axis_tvalid <= 1'b1;
      else if (m_axis_tvalid && m_axis_tready) m_axis_tvalid <= 1'b0;

      if (in_acc) begin
        case (in_op)
          pip_pkg::OP_CLEAR: count <= '0;
          pip_pkg::OP_APPEND: begin
            if (count < MAXV) count <= count + CW'(1);
          end
          default: ;
        endcase
      end

      // Sequencer read strobes.
      rd_v <= (state == pip_pkg::ST_RUN);
      close_pend <= rd_v && rd_last;

      // Edge launch: consecutive vertices, then the closing edge.
      e_v <= (rd_v && !rd_first) || close_pend;

      s1_v <= e_v;
      s2_v <= s1_v;
      s3_v <= s2_v;
      s4_v <= s3_v;
      s5_v <= s4_v;
    end
  end

  // ---------------------------------------------------------------- datapath
  always_ff @(posedge clk) begin
    if (in_acc) begin
      r_inside <= 1'b0;
      r_onb    <= 1'b0;
      r_cnt    <= '0;
      if (in_op == pip_pkg::OP_APPEND && count >= MAXV)
        r_status <= pip_pkg::STAT_FULL;
      else if (in_op == pip_pkg::OP_QUERY && count == '0)
        r_status <= pip_pkg::STAT_EMPTY;
      else
        r_status <= pip_pkg::STAT_OK;
      if (in_op == pip_pkg::OP_QUERY) begin
        px      <= in_x;
        py      <= in_y;
        n       <= count;
        issue   <= '0;
        acc_onb <= 1'b0;
        acc_cnt <= '0;
      end
    end

    if (state == pip_pkg::ST_RUN) begin
      rd_first <= (issue == '0);
      rd_last  <= (issue == n - CW'(1));
      issue    <= issue + CW'(1);
    end

    if (state == pip_pkg::ST_FINISH && out_free) begin
      m_axis_tdata <= {3'b000, r_status, r_cnt, r_onb, r_inside};
    end

    if (state == pip_pkg::ST_WAIT && pipe_empty) begin
      r_onb    <= acc_onb;
      r_cnt    <= acc_cnt;
      r_inside <= acc_onb | acc_cnt[0];
      r_status <= pip_pkg::STAT_OK;
    end

    // Hold the first vertex and the previous one; launch the edge.
    if (rd_v) begin
      if (rd_first) begin
        fx <= rx;
        fy <= ry;
      end else begin
        ax <= prvx;
        ay <= prvy;
        bx <= rx;
        by <= ry;
      end
      prvx <= rx;
      prvy <= ry;
    end
    if (close_pend) begin
      ax <= prvx;
      ay <= prvy;
      bx <= fx;
      by <= fy;
    end

    // Stage 1: differences and the half-open y range test.
    s1_dx    <= D'(bx) - D'(ax);
    s1_dy    <= D'(by) - D'(ay);
    s1_wx    <= D'(px) - D'(ax);
    s1_wy    <= D'(py) - D'(ay);
    s1_vx    <= D'(px) - D'(bx);
    s1_vy    <= D'(py) - D'(by);
    s1_yin   <= (ay <= py && py < by) || (by <= py && py < ay);
    s1_dypos <= (by > ay);

    // Stage 2: products.
    s2_dxwx  <= P'(s1_dx) * P'(s1_wx);
    s2_dywy  <= P'(s1_dy) * P'(s1_wy);
    s2_dxdx  <= P'(s1_dx) * P'(s1_dx);
    s2_dydy  <= P'(s1_dy) * P'(s1_dy);
    s2_dxwy  <= P'(s1_dx) * P'(s1_wy);
    s2_dywx  <= P'(s1_dy) * P'(s1_wx);
    s2_wxwx  <= P'(s1_wx) * P'(s1_wx);
    s2_wywy  <= P'(s1_wy) * P'(s1_wy);
    s2_vxvx  <= P'(s1_vx) * P'(s1_vx);
    s2_vyvy  <= P'(s1_vy) * P'(s1_vy);
    s2_lhs   <= P'(s1_wx) * P'(s1_dy);
    s2_rhs   <= P'(s1_wy) * P'(s1_dx);
    s2_yin   <= s1_yin;
    s2_dypos <= s1_dypos;

    // Stage 3: projection, length, cross product, endpoint distances, crossing decision.
    s3_t  <= S'(s2_dxwx) + S'(s2_dywy);
    s3_l  <= S'(s2_dxdx) + S'(s2_dydy);
    s3_cr <= S'(s2_dxwy) - S'(s2_dywx);
    s3_da <= S'(s2_wxwx) + S'(s2_wywy);
    s3_db <= S'(s2_vxvx) + S'(s2_vyvy);
    s3_xc <= s2_yin && (s2_dypos ? (s2_lhs < s2_rhs) : (s2_rhs < s2_lhs));

    // Stage 4: pick the clamped case; endpoint distances compare here.
    s4_acr    <= cr_abs;
    s4_l      <= s3_l;
    s4_ptmode <= (s3_l == '0) || t_nonpos || (s3_t >= s3_l);
    if ((s3_l == '0) || t_nonpos)
      s4_ptnear <= (s3_da <= S'(tol));
    else
      s4_ptnear <= (s3_db <= S'(tol));
    s4_xc     <= s3_xc;

    // Stage 5: square the cross product, scale the length by tolerance.
    s5_sq     <= Q'(s4_acr) * Q'(s4_acr);
    s5_tl     <= Q'(tol) * Q'(s4_l);
    s5_big    <= (acr_wide[127:62] != '0);
    s5_ptmode <= s4_ptmode;
    s5_ptnear <= s4_ptnear;
    s5_xc     <= s4_xc;

    // Stage 6: accumulate.
    if (s5_v) begin
      if (near6) acc_onb <= 1'b1;
      if (s5_xc && acc_cnt != pip_pkg::CNT_MAX) acc_cnt <= acc_cnt + CNT_ONE;
    end
  end

  // ---------------------------------------------------------------- checks
  `PIP_ASSERT_NOW(a_count_bound, 1'b1, count <= MAXV)
  `PIP_ASSERT_NEXT(a_append_grows, app_ok, count == $past(count) + CW'(1))
  `PIP_ASSERT_NOW(a_load_from_finish, $rose(m_axis_tvalid), $past(state) == pip_pkg::ST_FINISH)
  `PIP_ASSERT_NOW(a_issue_bound, state == pip_pkg::ST_RUN, issue < n)

endmodule
